FILE: hw/rtl/rpd_pkg.sv
package rpd_pkg;

    // Default limits of the decoder
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_ROWS_DEF  = 1024;

    // Source pixel formats
    localparam logic [1:0] FMT_ARGB8888 = 2'd0;
    localparam logic [1:0] FMT_ARGB4444 = 2'd1;
    localparam logic [1:0] FMT_BGRA4444 = 2'd2;
    localparam logic [1:0] FMT_RGB565   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_COLOR_FORMAT   = 3'd0;
    localparam logic [2:0] REG_ALPHA_EN       = 3'd1;
    localparam logic [2:0] REG_OPACITY        = 3'd2;
    localparam logic [2:0] REG_MAP_WIDTH      = 3'd3;
    localparam logic [2:0] REG_SKIP_ROWS      = 3'd4;
    localparam logic [2:0] REG_VISIBLE_ROWS   = 3'd5;
    localparam logic [2:0] REG_CLIP_FIRST_COL = 3'd6;
    localparam logic [2:0] REG_CLIP_LAST_COL  = 3'd7;

    // Register reset values
    localparam logic [1:0]  RST_COLOR_FORMAT   = FMT_ARGB8888;
    localparam logic        RST_ALPHA_EN       = 1'b1;
    localparam logic [7:0]  RST_OPACITY        = 8'hff;
    localparam logic [10:0] RST_MAP_WIDTH      = 11'd1024;
    localparam logic [9:0]  RST_SKIP_ROWS      = 10'd0;
    localparam logic [10:0] RST_VISIBLE_ROWS   = 11'd0;
    localparam logic [9:0]  RST_CLIP_FIRST_COL = 10'd0;
    localparam logic [9:0]  RST_CLIP_LAST_COL  = 10'd1023;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // Register file contents
    typedef struct packed {
        logic [1:0]  color_format;
        logic        alpha_en;
        logic [7:0]  opacity;
        logic [10:0] map_width;
        logic [9:0]  skip_rows;
        logic [10:0] visible_rows;
        logic [9:0]  clip_first_col;
        logic [9:0]  clip_last_col;
    } cfg_t;

    // Span geometry from the parser for the byte in progress
    typedef struct packed {
        logic        pix_done;
        logic        hit;
        logic [9:0]  row;
        logic [9:0]  start_col;
        logic [7:0]  span_length;
    } span_t;

    // Converted pixel
    typedef struct packed {
        logic        drawable;
        logic [23:0] color;
        logic [7:0]  alpha;
        logic        blend;
    } pix_t;

endpackage

FILE: hw/rtl/rpd_pixel.sv
module rpd_pixel (
    input  logic [31:0]  pixel_word,
    input  rpd_pkg::cfg_t cfg,
    output rpd_pkg::pix_t pix
);

    // a * b / 255 with truncation, exact for 8-bit operands
    function automatic logic [7:0] scale255(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] prod;
        logic [16:0] acc;
        prod = a * b;
        acc  = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;
        return acc[15:8];
    endfunction

    logic [3:0] nib_a;
    logic [3:0] nib_r;
    logic [3:0] nib_g;
    logic [3:0] nib_b;
    logic [7:0] alpha_src;
    logic [7:0] alpha_scaled;
    logic       brush_opaque;

    // Nibble unpack for the two 4444 layouts
    always_comb
    begin
        if (cfg.color_format == rpd_pkg::FMT_ARGB4444)
        begin
            nib_a = pixel_word[15:12];
            nib_r = pixel_word[11:8];
            nib_g = pixel_word[7:4];
            nib_b = pixel_word[3:0];
        end
        else
        begin
            nib_a = pixel_word[3:0];
            nib_r = pixel_word[7:4];
            nib_b = pixel_word[15:12];
            nib_g = pixel_word[11:8];
        end
    end

    // One shared alpha scaler: byte alpha for 8888, replicated nibble for 4444
    assign alpha_src    = (cfg.color_format == rpd_pkg::FMT_ARGB8888) ?
                          pixel_word[31:24] : {nib_a, nib_a};
    assign alpha_scaled = scale255(alpha_src, cfg.opacity);
    assign brush_opaque = (cfg.opacity == rpd_pkg::ALPHA_OPAQUE);

    // Color expansion and blend choice
    always_comb
    begin
        pix.drawable = 1'b1;
        pix.color    = pixel_word[23:0];
        pix.alpha    = rpd_pkg::ALPHA_OPAQUE;
        pix.blend    = 1'b0;
        case (cfg.color_format)
            rpd_pkg::FMT_ARGB8888:
            begin
                if (cfg.alpha_en)
                begin
                    pix.alpha = alpha_scaled;
                    pix.blend = 1'b1;
                end
                else if (!brush_opaque)
                begin
                    pix.alpha = cfg.opacity;
                    pix.blend = 1'b1;
                end
            end
            rpd_pkg::FMT_ARGB4444, rpd_pkg::FMT_BGRA4444:
            begin
                pix.drawable = (nib_a != 4'd0);
                pix.color    = {nib_r, 4'h0, nib_g, 4'h0, nib_b, 4'h0};
                pix.alpha    = alpha_scaled;
                pix.blend    = 1'b1;
            end
            default:
            begin
                pix.color = {pixel_word[15:11], 3'b000, pixel_word[10:5], 2'b00,
                             pixel_word[4:0], 3'b000};
                if (!brush_opaque)
                begin
                    pix.alpha = cfg.opacity;
                    pix.blend = 1'b1;
                end
            end
        endcase
    end

endmodule

FILE: hw/rtl/rpd_parser.sv
module rpd_parser #(
    parameter int MAX_WIDTH = rpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = rpd_pkg::MAX_ROWS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    data_byte,
    input  logic          start_image,
    input  rpd_pkg::cfg_t cfg,
    output logic [31:0]   pixel_word,
    output rpd_pkg::span_t span
);

    localparam int COL_RAW = $clog2(MAX_WIDTH + 256);
    localparam int COL_W   = (COL_RAW > 11) ? COL_RAW : 11;
    localparam int ROW_W   = $clog2(MAX_ROWS + 1025);

    // Parse state
    logic [2:0]       phase_reg,   phase_next;
    logic [7:0]       run_left_reg, run_left_next;
    logic             repeat_reg,  repeat_next;
    logic [31:0]      pix_reg,     pix_next;
    logic [COL_W-1:0] col_reg,     col_next;
    logic [ROW_W-1:0] rows_reg,    rows_next;

    // State after an optional restart
    logic [2:0]       phase;
    logic [7:0]       run_left;
    logic             rep;
    logic [31:0]      pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] rows;

    logic [1:0]       idx;
    logic             last_byte;
    logic [31:0]      pix_full;
    logic [ROW_W-1:0] vis;
    logic [ROW_W-1:0] limit;
    logic             done;
    logic [7:0]       n;
    logic [COL_W-1:0] col_end;
    logic [COL_W-1:0] last_raw;
    logic [COL_W-1:0] first_c;
    logic [COL_W-1:0] last_c;
    logic [COL_W-1:0] len_c;
    logic [COL_W-1:0] width;
    logic [ROW_W-1:0] row_rel;
    logic [7:0]       run_dec;

    assign phase    = start_image ? 3'd0  : phase_reg;
    assign run_left = start_image ? 8'd0  : run_left_reg;
    assign rep      = start_image ? 1'b0  : repeat_reg;
    assign pix      = start_image ? 32'd0 : pix_reg;
    assign col      = start_image ? '0    : col_reg;
    assign rows     = start_image ? '0    : rows_reg;

    // Row window
    assign vis   = (ROW_W'(cfg.visible_rows) > ROW_W'(MAX_ROWS)) ?
                   ROW_W'(MAX_ROWS) : ROW_W'(cfg.visible_rows);
    assign limit = ROW_W'(cfg.skip_rows) + vis;
    assign done  = (rows >= limit);

    // Byte lane assembly
    assign idx       = 2'(phase - 3'd1);
    assign pix_full  = pix | ({24'd0, data_byte} << {idx, 3'b000});
    assign last_byte = (cfg.color_format == rpd_pkg::FMT_ARGB8888) ?
                       (idx == 2'd3) : (idx != 2'd0);
    assign pixel_word = pix_full;

    // Span geometry and column clip
    assign n        = (!rep || run_left == 8'd0) ? 8'd1 : run_left;
    assign col_end  = col + COL_W'(n);
    assign last_raw = col_end - COL_W'(1);
    assign first_c  = (col > COL_W'(cfg.clip_first_col)) ? col : COL_W'(cfg.clip_first_col);
    assign last_c   = (last_raw > COL_W'(cfg.clip_last_col)) ?
                      COL_W'(cfg.clip_last_col) : last_raw;
    assign len_c    = last_c - first_c + COL_W'(1);
    assign row_rel  = rows - ROW_W'(cfg.skip_rows);

    // Effective row width
    assign width = (cfg.map_width == 11'd0) ? COL_W'(1) :
                   ((COL_W'(cfg.map_width) > COL_W'(MAX_WIDTH)) ?
                    COL_W'(MAX_WIDTH) : COL_W'(cfg.map_width));

    assign run_dec = (rep || run_left <= 8'd1) ? 8'd0 : run_left - 8'd1;

    assign span.pix_done    = !done && (phase != 3'd0) && last_byte;
    assign span.hit         = (rows >= ROW_W'(cfg.skip_rows)) && (first_c <= last_c);
    assign span.row         = row_rel[9:0];
    assign span.start_col   = first_c[9:0];
    assign span.span_length = len_c[7:0];

    // Next parse state
    always_comb
    begin
        phase_next    = phase;
        run_left_next = run_left;
        repeat_next   = rep;
        pix_next      = pix;
        col_next      = col;
        rows_next     = rows;
        if (!done)
        begin
            if (phase == 3'd0)
            begin
                // count byte
                repeat_next   = data_byte[7];
                run_left_next = {1'b0, data_byte[6:0]} + 8'd1;
                pix_next      = 32'd0;
                phase_next    = 3'd1;
            end
            else if (!last_byte)
            begin
                pix_next   = pix_full;
                phase_next = {1'b0, idx} + 3'd2;
            end
            else
            begin
                pix_next      = pix_full;
                col_next      = col_end;
                run_left_next = run_dec;
                if (run_dec == 8'd0)
                begin
                    phase_next = 3'd0;
                    if (col_end >= width)
                    begin
                        col_next  = '0;
                        rows_next = rows + ROW_W'(1);
                    end
                end
                else
                begin
                    phase_next = 3'd1;
                    pix_next   = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 3'd0;
            run_left_reg <= 8'd0;
            repeat_reg   <= 1'b0;
            pix_reg      <= 32'd0;
            col_reg      <= '0;
            rows_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            run_left_reg <= run_left_next;
            repeat_reg   <= repeat_next;
            pix_reg      <= pix_next;
            col_reg      <= col_next;
            rows_reg     <= rows_next;
        end
    end

endmodule

FILE: hw/rtl/rle_pixelmap_decoder_unit.sv
// Channel   Direction  Handshake              Contents
// in        input      in_valid / in_ready    data_byte, start_image
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
// out       output     out_valid / out_ready  row, start_col, span_length, color, alpha, blend
//
// One stream byte per cycle sustained while no command is held; a command is valid
// once its last pixel byte has passed the input register, then the result register.
// The parse state and clip logic sit between those two registers.
// Reset clears the parse state, the handshake flags and the registers to defaults.
// A held command stalls the input register; one more byte is still taken.
// cfg_ready is always high.
module rle_pixelmap_decoder_unit #(
    parameter int MAX_WIDTH = rpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = rpd_pkg::MAX_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_image,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  row,
    output logic [9:0]  start_col,
    output logic [7:0]  span_length,
    output logic [23:0] color,
    output logic [7:0]  alpha,
    output logic        blend
);

    rpd_pkg::cfg_t  cfg_reg;
    rpd_pkg::span_t span;
    rpd_pkg::pix_t  pix;

    logic        in_full_reg;
    logic        in_full_next;
    logic [7:0]  byte_reg;
    logic        start_reg;
    logic        fire;
    logic        emit;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] pixel_word;

    logic [9:0]  row_reg;
    logic [9:0]  start_col_reg;
    logic [7:0]  span_length_reg;
    logic [23:0] color_reg;
    logic [7:0]  alpha_reg;
    logic        blend_reg;

    // Register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_format   <= rpd_pkg::RST_COLOR_FORMAT;
            cfg_reg.alpha_en       <= rpd_pkg::RST_ALPHA_EN;
            cfg_reg.opacity        <= rpd_pkg::RST_OPACITY;
            cfg_reg.map_width      <= rpd_pkg::RST_MAP_WIDTH;
            cfg_reg.skip_rows      <= rpd_pkg::RST_SKIP_ROWS;
            cfg_reg.visible_rows   <= rpd_pkg::RST_VISIBLE_ROWS;
            cfg_reg.clip_first_col <= rpd_pkg::RST_CLIP_FIRST_COL;
            cfg_reg.clip_last_col  <= rpd_pkg::RST_CLIP_LAST_COL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rpd_pkg::REG_COLOR_FORMAT:   cfg_reg.color_format   <= cfg_data[1:0];
                rpd_pkg::REG_ALPHA_EN:       cfg_reg.alpha_en       <= cfg_data[0];
                rpd_pkg::REG_OPACITY:        cfg_reg.opacity        <= cfg_data[7:0];
                rpd_pkg::REG_MAP_WIDTH:      cfg_reg.map_width      <= cfg_data;
                rpd_pkg::REG_SKIP_ROWS:      cfg_reg.skip_rows      <= cfg_data[9:0];
                rpd_pkg::REG_VISIBLE_ROWS:   cfg_reg.visible_rows   <= cfg_data;
                rpd_pkg::REG_CLIP_FIRST_COL: cfg_reg.clip_first_col <= cfg_data[9:0];
                rpd_pkg::REG_CLIP_LAST_COL:  cfg_reg.clip_last_col  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Input register; a byte is processed when the result slot is free
    assign fire         = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready     = !in_full_reg || fire;
    assign in_full_next = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : in_full_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= data_byte;
            start_reg <= start_image;
        end
    end

    rpd_parser #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (fire),
        .data_byte   (byte_reg),
        .start_image (start_reg),
        .cfg         (cfg_reg),
        .pixel_word  (pixel_word),
        .span        (span)
    );

    rpd_pixel u_pixel (
        .pixel_word (pixel_word),
        .cfg        (cfg_reg),
        .pix        (pix)
    );

    // Command decision
    assign emit = span.pix_done && span.hit && pix.drawable && (cfg_reg.opacity != 8'd0);

    // Result register
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            row_reg         <= span.row;
            start_col_reg   <= span.start_col;
            span_length_reg <= span.span_length;
            color_reg       <= pix.color;
            alpha_reg       <= pix.alpha;
            blend_reg       <= pix.blend;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row         = row_reg;
    assign start_col   = start_col_reg;
    assign span_length = span_length_reg;
    assign color       = color_reg;
    assign alpha       = alpha_reg;
    assign blend       = blend_reg;

`ifndef SYNTHESIS
    // Clipped span is never empty and never longer than a run
    a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (span_length != 8'd0) && (span_length <= 8'd128))
        else $error("span length out of range");

    // Direct writes carry full opacity
    a_direct_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !blend) |-> (alpha == rpd_pkg::ALPHA_OPAQUE))
        else $error("direct write with partial alpha");

    // Input side stalls only behind a held byte
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_full_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a held command");

    // A new command only follows a processed byte
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(fire))
        else $error("command without a processed byte");
`endif

endmodule

FILE: tb/rpd_checker.sv
module rpd_checker
    import rpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_image,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [9:0]  row,
    input  logic [9:0]  start_col,
    input  logic [7:0]  span_length,
    input  logic [23:0] color,
    input  logic [7:0]  alpha,
    input  logic        blend,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [9:0]  row;
        logic [9:0]  start_col;
        logic [7:0]  span_length;
        logic [23:0] color;
        logic [7:0]  alpha;
        logic        blend;
    } span_cmd_t;

    // Shadow registers and parser state
    cfg_t        regs;
    logic [2:0]  phase_q;
    int unsigned run_left_q;
    bit          repeat_q;
    logic [31:0] pix_acc;
    int unsigned col_q;
    int unsigned rows_done;

    span_cmd_t expected_cmds[$];
    span_cmd_t got;
    span_cmd_t want;
    span_cmd_t predicted;
    bit        predicted_hit;

    function automatic void clear_parse();
        phase_q    = '0;
        run_left_q = 0;
        repeat_q   = 1'b0;
        pix_acc    = '0;
        col_q      = 0;
        rows_done  = 0;
    endfunction

    // Advance the parser by one stream byte; hit is set when a span comes out
    function automatic void decode_byte(input logic [7:0] b, input logic sof,
                                        output bit hit, output span_cmd_t cmd);
        int unsigned vis, bpp, idx, n, wid, lo_col, hi_col, row_now, a8;
        logic [3:0]  na, nr, ng, nb;
        logic [15:0] w565;
        logic [23:0] rgb;
        logic [7:0]  opa;
        bit          mix, drawable;

        hit = 1'b0;
        cmd = '0;
        if (sof)
            clear_parse();

        vis = (regs.visible_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : regs.visible_rows;
        if (rows_done >= regs.skip_rows + vis)
            return;

        bpp = (regs.color_format == FMT_ARGB8888) ? 4 : 2;

        // count byte opens a run
        if (phase_q == 0)
        begin
            repeat_q   = b[7];
            run_left_q = b[6:0] + 1;
            pix_acc    = '0;
            phase_q    = 3'd1;
            return;
        end

        // gather pixel bytes, least significant first
        idx = (phase_q - 1) & 3;
        pix_acc = pix_acc | (32'(b) << (8 * idx));
        if (idx + 1 < bpp)
        begin
            phase_q = 3'(idx + 2);
            return;
        end

        // pixel conversion
        opa      = ALPHA_OPAQUE;
        mix      = 1'b0;
        drawable = 1'b1;
        rgb      = '0;
        case (regs.color_format)
            FMT_ARGB8888:
            begin
                rgb = pix_acc[23:0];
                if (regs.alpha_en)
                begin
                    a8  = pix_acc[31:24];
                    a8  = a8 * regs.opacity / 255;
                    opa = a8[7:0];
                    mix = 1'b1;
                end
                else if (regs.opacity != ALPHA_OPAQUE)
                begin
                    opa = regs.opacity;
                    mix = 1'b1;
                end
            end
            FMT_ARGB4444, FMT_BGRA4444:
            begin
                if (regs.color_format == FMT_ARGB4444)
                begin
                    na = pix_acc[15:12];
                    nr = pix_acc[11:8];
                    ng = pix_acc[7:4];
                    nb = pix_acc[3:0];
                end
                else
                begin
                    na = pix_acc[3:0];
                    nr = pix_acc[7:4];
                    nb = pix_acc[15:12];
                    ng = pix_acc[11:8];
                end
                drawable = (na != 4'd0);
                rgb = {nr, 4'h0, ng, 4'h0, nb, 4'h0};
                a8  = {na, na};
                a8  = a8 * regs.opacity / 255;
                opa = a8[7:0];
                mix = 1'b1;
            end
            default:
            begin
                w565 = pix_acc[15:0];
                rgb  = {w565[15:11], 3'b000, w565[10:5], 2'b00, w565[4:0], 3'b000};
                if (regs.opacity != ALPHA_OPAQUE)
                begin
                    opa = regs.opacity;
                    mix = 1'b1;
                end
            end
        endcase

        // span geometry and column clip
        n = repeat_q ? run_left_q : 1;
        if (n == 0)
            n = 1;
        lo_col = (col_q > regs.clip_first_col) ? col_q : regs.clip_first_col;
        hi_col = col_q + n - 1;
        if (hi_col > regs.clip_last_col)
            hi_col = regs.clip_last_col;
        row_now = rows_done;
        hit = (rows_done >= regs.skip_rows) && (regs.opacity != 8'd0) &&
              drawable && (lo_col <= hi_col);

        // run bookkeeping and row end
        col_q = col_q + n;
        if (repeat_q || run_left_q <= 1)
            run_left_q = 0;
        else
            run_left_q = run_left_q - 1;

        if (run_left_q == 0)
        begin
            phase_q = '0;
            wid = (regs.map_width == 0) ? 1 :
                  ((regs.map_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : regs.map_width);
            if (col_q >= wid)
            begin
                col_q     = 0;
                rows_done = rows_done + 1;
            end
        end
        else
        begin
            phase_q = 3'd1;
            pix_acc = '0;
        end

        if (hit)
        begin
            cmd.row         = 10'(row_now - regs.skip_rows);
            cmd.start_col   = 10'(lo_col);
            cmd.span_length = 8'(hi_col - lo_col + 1);
            cmd.color       = rgb;
            cmd.alpha       = opa;
            cmd.blend       = mix;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.color_format   = RST_COLOR_FORMAT;
            regs.alpha_en       = RST_ALPHA_EN;
            regs.opacity        = RST_OPACITY;
            regs.map_width      = RST_MAP_WIDTH;
            regs.skip_rows      = RST_SKIP_ROWS;
            regs.visible_rows   = RST_VISIBLE_ROWS;
            regs.clip_first_col = RST_CLIP_FIRST_COL;
            regs.clip_last_col  = RST_CLIP_LAST_COL;
            clear_parse();
            expected_cmds.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // span request leaving the block
            if (out_valid && out_ready)
            begin
                got.row         = row;
                got.start_col   = start_col;
                got.span_length = span_length;
                got.color       = color;
                got.alpha       = alpha;
                got.blend       = blend;
                if (expected_cmds.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("rpd_checker: unexpected span %0d %0d %0d %06h %02h %0b",
                                 got.row, got.start_col, got.span_length, got.color,
                                 got.alpha, got.blend);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("rpd_checker: span mismatch");
                            $display("  expected %0d %0d %0d %06h %02h %0b",
                                     want.row, want.start_col, want.span_length,
                                     want.color, want.alpha, want.blend);
                            $display("  actual   %0d %0d %0d %06h %02h %0b",
                                     got.row, got.start_col, got.span_length,
                                     got.color, got.alpha, got.blend);
                        end
                    end
                end
            end

            // register write request
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COLOR_FORMAT:   regs.color_format   = cfg_data[1:0];
                    REG_ALPHA_EN:       regs.alpha_en       = cfg_data[0];
                    REG_OPACITY:        regs.opacity        = cfg_data[7:0];
                    REG_MAP_WIDTH:      regs.map_width      = cfg_data[10:0];
                    REG_SKIP_ROWS:      regs.skip_rows      = cfg_data[9:0];
                    REG_VISIBLE_ROWS:   regs.visible_rows   = cfg_data[10:0];
                    REG_CLIP_FIRST_COL: regs.clip_first_col = cfg_data[9:0];
                    REG_CLIP_LAST_COL:  regs.clip_last_col  = cfg_data[9:0];
                    default: ;
                endcase
            end

            // stream byte request
            if (in_valid && in_ready)
            begin
                decode_byte(data_byte, start_image, predicted_hit, predicted);
                if (predicted_hit)
                    expected_cmds.push_back(predicted);
            end

            pending = expected_cmds.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int          DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        start_image = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [9:0]  row;
    logic [9:0]  start_col;
    logic [7:0]  span_length;
    logic [23:0] color;
    logic [7:0]  alpha;
    logic        blend;

    int          fail_count;
    int          pending;

    int unsigned cycles = 0;
    int          burst_left = 0;
    int          item_count = 0;
    int          stall_mode = 0;
    int          mode_left = 0;
    int unsigned stall_tick = 0;

    // settings of the current phase, for the stream generator
    logic [1:0]  cur_fmt;
    int          cur_width;
    int          cur_skip;
    int          cur_vis;

    rle_pixelmap_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .start_image (start_image),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row         (row),
        .start_col   (start_col),
        .span_length (span_length),
        .color       (color),
        .alpha       (alpha),
        .blend       (blend)
    );

    rpd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .start_image (start_image),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row         (row),
        .start_col   (start_col),
        .span_length (span_length),
        .color       (color),
        .alpha       (alpha),
        .blend       (blend),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // span receiver: one of four random stall patterns, switched when its hold count runs out
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_tick % 5 != 0);
        endcase
    end

    // one stream byte request, sent in bursts with random gaps
    task automatic push(input logic [7:0] b, input logic sof);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        data_byte   <= b;
        start_image <= sof;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        item_count++;
    endtask

    // drop valid and wait until every predicted span has come out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_put(input logic [2:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 11'(val);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic cfg_done();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input int fmt, input int has_a, input int brush, input int width,
                               input int skip, input int vis, input int c_lo, input int c_hi);
        cfg_put(REG_COLOR_FORMAT, fmt);
        cfg_put(REG_ALPHA_EN, has_a);
        cfg_put(REG_OPACITY, brush);
        cfg_put(REG_MAP_WIDTH, width);
        cfg_put(REG_SKIP_ROWS, skip);
        cfg_put(REG_VISIBLE_ROWS, vis);
        cfg_put(REG_CLIP_FIRST_COL, c_lo);
        cfg_put(REG_CLIP_LAST_COL, c_hi);
        cfg_done();
        cur_fmt   = 2'(fmt);
        cur_width = (width == 0) ? 1 : ((width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width);
        cur_skip  = skip;
        cur_vis   = (vis > MAX_ROWS_DEF) ? MAX_ROWS_DEF : vis;
    endtask

    // random settings, with the extremes forced in the first phases
    task automatic random_config(input int pno);
        int fmt, has_a, brush, width, skip, vis, c_lo, c_hi, r;
        fmt   = $urandom_range(0, 3);
        has_a = $urandom_range(0, 1);
        r = $urandom_range(0, 9);
        brush = (r == 0) ? 0 : ((r <= 3) ? 255 : $urandom_range(1, 254));
        r = $urandom_range(0, 9);
        width = (r == 0) ? 0 : (r == 1) ? 1024 : (r == 2) ? 2047 :
                (r == 3) ? $urandom_range(25, 1023) : $urandom_range(1, 24);
        skip = ($urandom_range(0, 15) == 0) ? 1023 : $urandom_range(0, 3);
        r = $urandom_range(0, 9);
        vis = (r == 0) ? 0 : (r == 1) ? 1024 : (r == 2) ? 2047 : $urandom_range(1, 6);
        c_lo = ($urandom_range(0, 11) == 0) ? 1023 : $urandom_range(0, 8);
        c_hi = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(2, 40);
        case (pno)
            0:
            begin
                width = 0;
                brush = 0;
            end
            1:
            begin
                width = 2047;
                vis   = 2047;
                fmt   = FMT_RGB565;
                brush = 255;
                skip  = 0;
            end
            2:
            begin
                width = 1024;
                vis   = 1024;
                c_lo  = 0;
                c_hi  = 1023;
                fmt   = FMT_ARGB8888;
                has_a = 0;
                skip  = 0;
            end
            3: skip = 1023;
            4:
            begin
                c_lo  = 1023;
                c_hi  = 0;
                brush = 255;
            end
            5:
            begin
                fmt   = FMT_ARGB8888;
                has_a = 1;
                brush = 255;
                width = 8;
                skip  = 0;
                vis   = 3;
            end
            6:
            begin
                fmt   = FMT_BGRA4444;
                brush = $urandom_range(1, 254);
                skip  = 1;
                vis   = 4;
            end
            7: vis = 0;
            default: ;
        endcase
        load_config(fmt, has_a, brush, width, skip, vis, c_lo, c_hi);
    endtask

    // image: runs with random content until the drawn rows are done or the byte budget is spent
    task automatic gen_image(input bit with_start);
        int  budget, runs, npix, bpp, gcol, grows, target, k, j;
        int  cnt;
        bit  rep, sof;
        bpp    = (cur_fmt == FMT_ARGB8888) ? 4 : 2;
        budget = 400;
        runs   = 0;
        gcol   = 0;
        grows  = 0;
        sof    = with_start;
        target = cur_skip + cur_vis;
        while (budget > 0 && (grows < target || runs < 2))
        begin
            rep = ($urandom_range(0, 99) < 45);
            case ($urandom_range(0, 19))
                0:       cnt = $urandom_range(0, 127);
                1, 2:    cnt = $urandom_range(8, 40);
                default: cnt = $urandom_range(0, 7);
            endcase
            if (rep && cur_width > 64 && $urandom_range(0, 1) == 1)
                cnt = $urandom_range(64, 127);
            push({rep, 7'(cnt)}, sof);
            sof = 1'b0;
            budget--;
            runs++;
            npix = rep ? 1 : cnt + 1;
            for (k = 0; k < npix; k++)
            begin
                for (j = 0; j < bpp; j++)
                begin
                    // broken run: give up mid-pixel
                    if ($urandom_range(0, 299) == 0)
                        return;
                    push(8'($urandom), 1'b0);
                    budget--;
                end
            end
            gcol = gcol + cnt + 1;
            if (gcol >= cur_width)
            begin
                gcol = 0;
                grows++;
            end
        end
        // trailing bytes after the last row are dropped by the block
        repeat ($urandom_range(0, 2)) push(8'($urandom), 1'b0);
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(4, 30)) push(8'($urandom), ($urandom_range(0, 7) == 0));
    endtask

    initial
    begin
        int pno;
        int r;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: argb8888 with per-pixel alpha, 8 wide, 4 rows
        load_config(FMT_ARGB8888, 1, 255, 8, 0, 4, 0, 1023);
        push(8'h83, 1'b1);                      // repeat of 4
        push(8'hff, 1'b0);
        push(8'h00, 1'b0);
        push(8'h80, 1'b0);
        push(8'hff, 1'b0);
        push(8'h01, 1'b0);                      // two literals, alpha 0 and 255
        push(8'h12, 1'b0);
        push(8'h34, 1'b0);
        push(8'h56, 1'b0);
        push(8'h00, 1'b0);
        push(8'hab, 1'b0);
        push(8'hcd, 1'b0);
        push(8'hef, 1'b0);
        push(8'hff, 1'b0);
        push(8'hff, 1'b0);                      // repeat of 128 past the row end
        push(8'h00, 1'b0);
        push(8'h00, 1'b0);
        push(8'h00, 1'b0);
        push(8'h00, 1'b0);
        settle();

        // directed: argb4444 at half brush, transparent pixel then a literal
        load_config(FMT_ARGB4444, 1, 128, 8, 0, 4, 0, 1023);
        push(8'h81, 1'b1);
        push(8'h34, 1'b0);
        push(8'h05, 1'b0);
        push(8'h00, 1'b0);
        push(8'hab, 1'b0);
        push(8'hf1, 1'b0);

        // random phases
        item_count = 0;
        pno = 0;
        while (item_count < 2000)
        begin
            settle();
            random_config(pno);
            pno++;
            repeat ($urandom_range(1, 3))
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    gen_noise();
                else
                    gen_image(r > 3);
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
